// ===== rtl/core/sbh_pkg.sv =====
// ----------------------------------------------------------------------------
// sbh_pkg
// Shared widths, algorithm codes and start values of the string bucket hash.
// ----------------------------------------------------------------------------
package sbh_pkg;

  localparam int unsigned CHAR_W               = 8;
  localparam int unsigned HASH_W               = 32;
  localparam int unsigned BUCKET_W             = 8;
  localparam int unsigned ALG_W                = 3;
  localparam int unsigned DEFAULT_BUCKET_COUNT = 131;

  localparam logic [HASH_W-1:0] JS_SEED  = 32'd1315423911;
  localparam logic [HASH_W-1:0] DJB_SEED = 32'd5381;

  // Algorithm select codes; unused codes fall back to ELF
  typedef enum logic [ALG_W-1:0] {
    ALG_ELF  = 3'd0,
    ALG_BKDR = 3'd1,
    ALG_SDBM = 3'd2,
    ALG_JS   = 3'd3,
    ALG_DJB  = 3'd4,
    ALG_AP   = 3'd5
  } alg_e;

  // Start value of the running hash for an algorithm
  function automatic logic [HASH_W-1:0] start_value(alg_e alg);
    logic [HASH_W-1:0] v;
    case (alg)
      ALG_JS:  v = JS_SEED;
      ALG_DJB: v = DJB_SEED;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/sbh_if.sv =====
// ----------------------------------------------------------------------------
// sbh_if
// Valid/ready channels of the string bucket hash: byte input and result.
// ----------------------------------------------------------------------------
interface sbh_char_if import sbh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink   (input valid, input char_byte, output ready);
endinterface

interface sbh_result_if import sbh_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BUCKET_W-1:0] bucket;
  logic [HASH_W-1:0]   hash_value;

  modport source (output valid, output bucket, output hash_value, input ready);
  modport sink   (input valid, input bucket, input hash_value, output ready);
endinterface

// ===== rtl/core/sbh_hash_unit.sv =====
// ----------------------------------------------------------------------------
// sbh_hash_unit
// Algorithm register and running hash; folds in one byte per transaction.
// ----------------------------------------------------------------------------
module sbh_hash_unit import sbh_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ALG_W-1:0]  cfg_wdata_i,
  input  logic              fire_i,
  input  logic [CHAR_W-1:0] char_byte_i,
  output logic [HASH_W-1:0] hash_o
);

  alg_e              alg_q;
  logic [HASH_W-1:0] hash_q, hash_d;
  logic              odd_q;
  logic [HASH_W-1:0] upd;
  logic [HASH_W-1:0] c;
  logic [HASH_W-1:0] elf_t;
  logic [HASH_W-1:0] elf_top;

  assign c = HASH_W'(char_byte_i);

  // Compute the per-byte update for the selected algorithm
  always_comb begin
    elf_t   = (hash_q << 4) + c;
    elf_top = elf_t & 32'hF000_0000;
    case (alg_q)
      ALG_BKDR: upd = (hash_q << 7) + (hash_q << 1) + hash_q + c;
      ALG_SDBM: upd = c + (hash_q << 6) + (hash_q << 16) - hash_q;
      ALG_JS:   upd = hash_q ^ ((hash_q << 5) + c + (hash_q >> 2));
      ALG_DJB:  upd = hash_q + (hash_q << 5) + c;
      ALG_AP: begin
        if (!odd_q) begin
          upd = hash_q ^ ((hash_q << 7) ^ c ^ (hash_q >> 3));
        end else begin
          upd = hash_q ^ ~((hash_q << 11) ^ c ^ (hash_q >> 5));
        end
      end
      default:  upd = (elf_t ^ (elf_top >> 24)) & ~elf_top;
    endcase
    hash_d = upd;
  end

  // Restart on a register write or a terminating byte, else advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alg_q  <= ALG_ELF;
      hash_q <= start_value(ALG_ELF);
      odd_q  <= 1'b0;
    end else if (cfg_we_i) begin
      alg_q  <= alg_e'(cfg_wdata_i);
      hash_q <= start_value(alg_e'(cfg_wdata_i));
      odd_q  <= 1'b0;
    end else if (fire_i) begin
      if (char_byte_i == '0) begin
        hash_q <= start_value(alg_q);
        odd_q  <= 1'b0;
      end else begin
        hash_q <= hash_d;
        odd_q  <= ~odd_q;
      end
    end
  end

  assign hash_o = hash_q;

endmodule

// ===== rtl/core/sbh_bucket_mod.sv =====
// ----------------------------------------------------------------------------
// sbh_bucket_mod
// Pipelined bucket reduction: masked hash modulo the bucket count by a
// reciprocal multiply, a back multiply and one corrective subtract.
// ----------------------------------------------------------------------------
module sbh_bucket_mod import sbh_pkg::*; #(
  parameter int unsigned BUCKET_COUNT = DEFAULT_BUCKET_COUNT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [HASH_W-1:0]   in_hash_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [BUCKET_W-1:0] out_bucket_o,
  output logic [HASH_W-1:0]   out_hash_o
);

  // Quotient estimate floor(x*M / 2^K) is low by at most one
  localparam int unsigned X_W    = HASH_W - 1;
  localparam int unsigned D_W    = $clog2(BUCKET_COUNT + 1);
  localparam int unsigned SHIFT  = X_W + $clog2(BUCKET_COUNT);
  localparam int unsigned M_W    = 32;
  localparam int unsigned PROD_W = X_W + M_W;
  localparam int unsigned QD_W   = X_W + D_W;
  localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / 64'(BUCKET_COUNT);
  localparam logic [M_W-1:0] RECIP   = RECIP_FULL[M_W-1:0];
  localparam logic [X_W-1:0] DIVISOR = X_W'(BUCKET_COUNT);

  logic                v1_q, v2_q, v3_q, v4_q;
  logic                rdy1, rdy2, rdy3, rdy4;
  logic [X_W-1:0]      x1_q, x2_q, x3_q;
  logic [HASH_W-1:0]   h1_q, h2_q, h3_q, h4_q;
  logic [PROD_W-1:0]   prod_d, prod_q;
  logic [PROD_W-1:0]   quot_full;
  logic [X_W-1:0]      quot;
  logic [QD_W-1:0]     qd_full;
  logic [X_W-1:0]      qd_q;
  logic [X_W-1:0]      diff;
  logic [X_W-1:0]      rem;
  logic [BUCKET_W-1:0] bucket_q;

  // Advance a stage when it is empty or its successor moves
  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // Datapath between stages
  assign prod_d    = PROD_W'(x1_q) * PROD_W'(RECIP);
  assign quot_full = prod_q >> SHIFT;
  assign quot      = quot_full[X_W-1:0];
  assign qd_full   = QD_W'(quot) * QD_W'(BUCKET_COUNT);
  assign diff      = x3_q - qd_q;
  assign rem       = (diff >= DIVISOR) ? (diff - DIVISOR) : diff;

  // Hold stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Move payload along with the valids
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      x1_q <= in_hash_i[X_W-1:0];
      h1_q <= in_hash_i;
    end
    if (rdy2) begin
      prod_q <= prod_d;
      x2_q   <= x1_q;
      h2_q   <= h1_q;
    end
    if (rdy3) begin
      qd_q <= qd_full[X_W-1:0];
      x3_q <= x2_q;
      h3_q <= h2_q;
    end
    if (rdy4) begin
      bucket_q <= rem[BUCKET_W-1:0];
      h4_q     <= h3_q;
    end
  end

  assign out_valid_o  = v4_q;
  assign out_bucket_o = bucket_q;
  assign out_hash_o   = h4_q;

endmodule

// ===== rtl/core/string_bucket_hash_core.sv =====
// ----------------------------------------------------------------------------
// string_bucket_hash_core
// Per-byte string hash (ELF, BKDR, SDBM, JS, DJB, AP) with bucket reduction.
// ----------------------------------------------------------------------------
// One string byte is taken per cycle while the reduction pipeline has room;
// the running hash register takes a combinational per-byte update, which
// sets that rate. A zero byte ends the string: its 32-bit hash and bucket
// (hash & 0x7fffffff mod BUCKET_COUNT) pass through the four registered
// stages of the reduction pipeline to the result channel; the pipeline keeps
// taking bytes while a result waits, until all its stages are full. Writing
// the algorithm register restarts the string.
module string_bucket_hash_core import sbh_pkg::*; #(
  parameter int unsigned BUCKET_COUNT = DEFAULT_BUCKET_COUNT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ALG_W-1:0]  cfg_wdata_i,
  sbh_char_if.sink          char_i,
  sbh_result_if.source      result_o
);

  logic              fire;
  logic              term;
  logic              mod_ready;
  logic [HASH_W-1:0] hash;

  // Accept a byte when the reduction pipeline has room
  assign char_i.ready = mod_ready;
  assign fire         = char_i.valid && mod_ready;
  assign term         = fire && (char_i.char_byte == '0);

  sbh_hash_unit u_hash (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .char_byte_i (char_i.char_byte),
    .hash_o      (hash)
  );

  sbh_bucket_mod #(
    .BUCKET_COUNT (BUCKET_COUNT)
  ) u_mod (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (term),
    .in_ready_o   (mod_ready),
    .in_hash_i    (hash),
    .out_valid_o  (result_o.valid),
    .out_ready_i  (result_o.ready),
    .out_bucket_o (result_o.bucket),
    .out_hash_o   (result_o.hash_value)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for string_bucket_hash_core. A bench-side hash model
// follows every accepted byte and register write, and queues the hash and
// bucket that each terminating zero byte should produce. A checker compares
// each result transaction with the oldest queued one. The stimulus is a
// directed part followed by random strings under every algorithm code, with
// random gaps on the byte channel and random stalls on the result channel.
// ----------------------------------------------------------------------------
module testbench;
  import sbh_pkg::*;

  localparam int unsigned BUCKETS      = 131;
  localparam int unsigned PHASE_ITEMS  = 75;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT  = 300000;

  // Unused select codes; the block decodes them as ELF
  localparam logic [ALG_W-1:0] ALG_SPARE_LO = 3'd6;
  localparam logic [ALG_W-1:0] ALG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [BUCKET_W-1:0] bucket;
    logic [HASH_W-1:0]   hash_value;
  } hash_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [ALG_W-1:0] cfg_wdata_i;

  sbh_char_if   char_ch ();
  sbh_result_if res_ch ();

  string_bucket_hash_core #(
    .BUCKET_COUNT(BUCKETS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .char_i     (char_ch),
    .result_o   (res_ch)
  );

  // Hash model state, mirrors the block after each clock edge
  logic [ALG_W-1:0]  model_alg  = ALG_ELF;
  logic [HASH_W-1:0] model_hash = '0;
  logic              model_odd  = 1'b0;

  hash_result_t expected_results[$];
  int           error_count   = 0;
  int           cycle_count   = 0;
  bit           source_gaps   = 1'b0;
  bit           sink_stalls   = 1'b0;
  int           stall_left    = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Hash model
  // --------------------------------------------------------------------------
  function automatic logic [HASH_W-1:0] alg_seed(logic [ALG_W-1:0] alg);
    logic [HASH_W-1:0] s;
    case (alg)
      ALG_JS:  s = JS_SEED;
      ALG_DJB: s = DJB_SEED;
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [HASH_W-1:0] hash_step(logic [ALG_W-1:0] alg,
                                                  logic [HASH_W-1:0] h,
                                                  logic [CHAR_W-1:0] ch,
                                                  logic odd);
    logic [HASH_W-1:0] c;
    logic [HASH_W-1:0] t;
    logic [HASH_W-1:0] top;
    c = {{(HASH_W-CHAR_W){1'b0}}, ch};
    case (alg)
      ALG_BKDR: t = h * 32'd131 + c;
      ALG_SDBM: t = c + (h << 6) + (h << 16) - h;
      ALG_JS:   t = h ^ ((h << 5) + c + (h >> 2));
      ALG_DJB:  t = h + (h << 5) + c;
      ALG_AP: begin
        // alternate the update by byte position
        if (!odd) t = h ^ ((h << 7) ^ c ^ (h >> 3));
        else      t = h ^ ~((h << 11) ^ c ^ (h >> 5));
      end
      default: begin
        // fold the top nibble into bits 7..4, then clear it
        t   = (h << 4) + c;
        top = t & 32'hF000_0000;
        t   = (t ^ (top >> 24)) & ~top;
      end
    endcase
    return t;
  endfunction

  function automatic logic [BUCKET_W-1:0] bucket_of(logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] m;
    m = (h & 32'h7FFF_FFFF) % BUCKETS;
    return m[BUCKET_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Track writes and bytes, check results
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    hash_result_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        model_alg  = cfg_wdata_i;
        model_hash = alg_seed(cfg_wdata_i);
        model_odd  = 1'b0;
      end
      if (char_ch.valid && char_ch.ready) begin
        if (char_ch.char_byte != '0) begin
          model_hash = hash_step(model_alg, model_hash, char_ch.char_byte, model_odd);
          model_odd  = ~model_odd;
        end else begin
          expected_results.push_back('{bucket_of(model_hash), model_hash});
          model_hash = alg_seed(model_alg);
          model_odd  = 1'b0;
        end
      end
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transaction bucket=%0d hash=%h",
                   $time, res_ch.bucket, res_ch.hash_value);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (res_ch.bucket !== want.bucket) begin
            $display("%0t: bucket mismatch: expected %0d, actual %0d",
                     $time, want.bucket, res_ch.bucket);
            error_count++;
          end
          if (res_ch.hash_value !== want.hash_value) begin
            $display("%0t: hash_value mismatch: expected %h, actual %h",
                     $time, want.hash_value, res_ch.hash_value);
            error_count++;
          end
        end
      end
    end
  end

  // Stall the result channel: mostly short stalls, a few long ones
  always @(posedge clk_i) begin
    int roll;
    if (!sink_stalls) begin
      res_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left   = stall_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        res_ch.ready <= 1'b1;
      end else begin
        stall_left   = (roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        res_ch.ready <= 1'b0;
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int roll;
    if (!source_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [CHAR_W-1:0] rand_char();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8)  return 8'hFF;
    if (roll < 12) return 8'h01;
    if (roll < 16) return 8'h80;
    return CHAR_W'($urandom_range(1, 255));
  endfunction

  function automatic int rand_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 6)  return 0;
    if (roll < 88) return $urandom_range(1, 12);
    return $urandom_range(13, 48);
  endfunction

  // Send one byte, hold it until the transaction completes
  task automatic send_byte(input logic [CHAR_W-1:0] ch);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      char_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    char_ch.valid     <= 1'b1;
    char_ch.char_byte <= ch;
    do @(posedge clk_i); while (!char_ch.ready);
  endtask

  // Send random nonzero bytes, optionally followed by the terminating zero
  task automatic send_string(input int len, input bit terminate);
    for (int i = 0; i < len; i++) send_byte(rand_char());
    if (terminate) send_byte('0);
  endtask

  // Hold off the byte channel until all results are out and the pipe is empty
  task automatic wait_idle();
    char_ch.valid <= 1'b0;
    // let the model record the last accepted byte first
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_alg(input logic [ALG_W-1:0] code);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= code;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset selects ELF: empty string, then a run long enough to fold the top
  task automatic test_reset_elf();
    send_byte('0);
    repeat (7) send_byte(8'hFF);
    send_byte('0);
  endtask

  // Each algorithm but ELF on a short string; empty strings where the seed is nonzero
  task automatic test_algorithms();
    alg_e alg;
    alg = ALG_BKDR;
    forever begin
      wait_idle();
      write_alg(alg);
      if (alg == ALG_JS || alg == ALG_DJB) send_byte('0);
      send_byte(8'hFF);
      send_byte(8'h01);
      send_byte('0);
      if (alg == ALG_AP) break;
      alg = alg.next();
    end
  endtask

  // A register write discards the partial string and reseeds
  task automatic test_restart_on_write();
    wait_idle();
    write_alg(ALG_DJB);
    send_byte(8'h41);
    send_byte(8'h42);
    wait_idle();
    write_alg(ALG_JS);
    send_byte(8'h43);
    send_byte('0);
  endtask

  // Random strings under every select code, with varying idling
  task automatic test_random_strings();
    logic [ALG_W-1:0] phase_alg [8];
    int               sent;
    int               len;
    bit               paused;
    phase_alg = '{ALG_SPARE_HI, ALG_ELF, ALG_AP, ALG_JS,
                  ALG_BKDR, ALG_SPARE_LO, ALG_DJB, ALG_SDBM};
    paused = 1'b0;
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      write_alg(phase_alg[p]);
      source_gaps = (p != 0 && p != 2);
      sink_stalls = (p != 0 && p != 1);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = rand_len();
        send_string(len, 1'b1);
        sent += len + 1;
        // drain everything once in the middle of a phase
        if (p == 3 && !paused && sent >= PHASE_ITEMS / 2) begin
          wait_idle();
          paused = 1'b1;
        end
      end
      // leave a partial string for the next write to discard
      if (p % 2 == 1) send_string($urandom_range(1, 5), 1'b0);
    end
  endtask

  initial begin
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= ALG_ELF;
    char_ch.valid     <= 1'b0;
    char_ch.char_byte <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    source_gaps = 1'b1;
    sink_stalls = 1'b1;
    test_reset_elf();
    test_algorithms();
    test_restart_on_write();
    test_random_strings();
    wait_idle();

    if (error_count == 0) $display("CHECK OK");
    else                  $display("CHECK FAILED");
    $finish;
  end

endmodule
